[rtl/core/i2cseq_pkg.sv]
// Package: item, result and state types plus codes for the I2C transfer sequencer.
`default_nettype none
package i2cseq_pkg;

    typedef enum logic [2:0] {
        ACT_START_WR = 3'd0,
        ACT_START_RD = 3'd1,
        ACT_LOAD     = 3'd2,
        ACT_EVENT    = 3'd3,
        ACT_ERROR    = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_REG  = 2'd1,
        KIND_DATA = 2'd2,
        KIND_RX   = 2'd3
    } kind_t;

    localparam logic [1:0] PHASE_IDLE  = 2'd0;
    localparam logic [1:0] PHASE_FIRST = 2'd1;
    localparam logic [1:0] PHASE_RX    = 2'd2;

    // interrupt-enable mask bit positions
    localparam int EN_TX   = 0;
    localparam int EN_RX   = 1;
    localparam int EN_TC   = 2;
    localparam int EN_NACK = 3;
    localparam int EN_STOP = 4;
    localparam int EN_ERR  = 5;

    localparam logic [7:0] NO_REGISTER  = 8'hFF;
    localparam int         ERR_ARB_LOST = 1;

    typedef struct packed {
        action_t    action;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] byte_count;
        logic [7:0] data_byte;
        logic [7:0] buffer_index;
        logic       stop_detected;
        logic       nack_seen;
        logic       transfer_complete;
        logic       rx_not_empty;
        logic       tx_empty;
        logic [4:0] error_flags;
    } item_t;

    typedef struct packed {
        logic       accepted;
        logic       ctl_valid;
        logic [7:0] ctl_slave_addr;
        logic [8:0] ctl_byte_count;
        logic       ctl_receive;
        logic       ctl_auto_end;
        kind_t      data_kind;
        logic [7:0] out_byte;
        logic [7:0] out_index;
        logic       stop_request;
        logic       busy_res;
        logic       error;
    } result_t;

    typedef struct packed {
        logic       busy;
        logic       err;
        logic       is_write;
        logic [1:0] phase;
        logic [7:0] pos;
        logic       reg_sent;
        logic [5:0] mask;
        logic [7:0] target;
        logic [7:0] reg_byte;
        logic [7:0] len;
    } state_t;

endpackage
`default_nettype wire

[rtl/core/i2cseq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module i2cseq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                 clk,
    input  wire logic                                 wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                     wr_data,
    input  wire logic                                 rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

[rtl/core/i2cseq_step.sv]
// Next-state and result logic for one item of the transfer sequencer.
`default_nettype none
module i2cseq_step (
    input  wire i2cseq_pkg::state_t st,
    input  wire i2cseq_pkg::item_t  item,
    input  wire logic [7:0]     buf_byte,   // write buffer entry at st.pos (0 past the end)
    output i2cseq_pkg::state_t  st_next,
    output i2cseq_pkg::result_t res
);

    logic has_reg;

    assign has_reg = item.reg_addr != i2cseq_pkg::NO_REGISTER;

    always_comb
    begin
        st_next = st;
        res     = '0;
        case (item.action)
            i2cseq_pkg::ACT_START_WR, i2cseq_pkg::ACT_START_RD:
            begin
                if (!st.busy)
                begin
                    st_next.target   = {item.dev_addr, 1'b0};
                    st_next.reg_byte = item.reg_addr;
                    st_next.len      = item.byte_count;
                    st_next.busy     = 1'b1;
                    st_next.err      = 1'b0;
                    st_next.pos      = '0;
                    st_next.reg_sent = !has_reg;
                    res.accepted       = 1'b1;
                    res.ctl_valid      = 1'b1;
                    res.ctl_slave_addr = {item.dev_addr, 1'b0};
                    if (item.action == i2cseq_pkg::ACT_START_WR)
                    begin
                        st_next.is_write = 1'b1;
                        st_next.phase    = i2cseq_pkg::PHASE_FIRST;
                        st_next.mask     = '0;
                        st_next.mask[i2cseq_pkg::EN_TX]   = 1'b1;
                        st_next.mask[i2cseq_pkg::EN_NACK] = 1'b1;
                        st_next.mask[i2cseq_pkg::EN_STOP] = 1'b1;
                        st_next.mask[i2cseq_pkg::EN_ERR]  = 1'b1;
                        res.ctl_byte_count = {1'b0, item.byte_count} + {8'd0, has_reg};
                        res.ctl_auto_end   = 1'b1;
                    end
                    else if (has_reg)
                    begin
                        // register phase first, no STOP, then repeated start
                        st_next.is_write = 1'b0;
                        st_next.phase    = i2cseq_pkg::PHASE_FIRST;
                        st_next.mask     = '0;
                        st_next.mask[i2cseq_pkg::EN_TX]   = 1'b1;
                        st_next.mask[i2cseq_pkg::EN_TC]   = 1'b1;
                        st_next.mask[i2cseq_pkg::EN_NACK] = 1'b1;
                        st_next.mask[i2cseq_pkg::EN_STOP] = 1'b1;
                        st_next.mask[i2cseq_pkg::EN_ERR]  = 1'b1;
                        res.ctl_byte_count = 9'd1;
                    end
                    else
                    begin
                        st_next.is_write = 1'b0;
                        st_next.phase    = i2cseq_pkg::PHASE_RX;
                        st_next.mask     = '0;
                        st_next.mask[i2cseq_pkg::EN_RX]   = 1'b1;
                        st_next.mask[i2cseq_pkg::EN_NACK] = 1'b1;
                        st_next.mask[i2cseq_pkg::EN_STOP] = 1'b1;
                        st_next.mask[i2cseq_pkg::EN_ERR]  = 1'b1;
                        res.ctl_byte_count = {1'b0, item.byte_count};
                        res.ctl_receive    = 1'b1;
                        res.ctl_auto_end   = 1'b1;
                    end
                end
            end
            i2cseq_pkg::ACT_EVENT:
            begin
                // fixed priority: STOP, NACK, transfer complete, receive, transmit
                if (st.mask[i2cseq_pkg::EN_STOP] && item.stop_detected)
                begin
                    if (item.nack_seen)
                    begin
                        st_next.err = 1'b1;
                    end
                    st_next.mask  = '0;
                    st_next.phase = i2cseq_pkg::PHASE_IDLE;
                    st_next.busy  = 1'b0;
                end
                else if (st.mask[i2cseq_pkg::EN_NACK] && item.nack_seen)
                begin
                    st_next.err  = 1'b1;
                    st_next.mask = '0;
                    st_next.mask[i2cseq_pkg::EN_STOP] = st.mask[i2cseq_pkg::EN_STOP];
                    if (item.stop_detected)
                    begin
                        st_next.mask  = '0;
                        st_next.phase = i2cseq_pkg::PHASE_IDLE;
                        st_next.busy  = 1'b0;
                    end
                end
                else if (st.mask[i2cseq_pkg::EN_TC] && item.transfer_complete)
                begin
                    if (!st.is_write && st.reg_sent && st.phase == i2cseq_pkg::PHASE_FIRST)
                    begin
                        st_next.mask  = '0;
                        st_next.pos   = '0;
                        st_next.phase = i2cseq_pkg::PHASE_RX;
                        if (st.len == 8'd0)
                        begin
                            // empty receive phase
                            st_next.err  = 1'b1;
                            st_next.busy = 1'b0;
                        end
                        else
                        begin
                            st_next.mask[i2cseq_pkg::EN_RX]   = 1'b1;
                            st_next.mask[i2cseq_pkg::EN_NACK] = 1'b1;
                            st_next.mask[i2cseq_pkg::EN_STOP] = 1'b1;
                            st_next.mask[i2cseq_pkg::EN_ERR]  = 1'b1;
                            res.ctl_valid      = 1'b1;
                            res.ctl_slave_addr = st.target;
                            res.ctl_byte_count = {1'b0, st.len};
                            res.ctl_receive    = 1'b1;
                            res.ctl_auto_end   = 1'b1;
                        end
                    end
                end
                else if (st.mask[i2cseq_pkg::EN_RX] && item.rx_not_empty)
                begin
                    if (st.pos < st.len)
                    begin
                        res.data_kind = i2cseq_pkg::KIND_RX;
                        res.out_byte  = item.data_byte;
                        res.out_index = st.pos;
                        st_next.pos   = st.pos + 8'd1;
                    end
                end
                else if (st.mask[i2cseq_pkg::EN_TX] && item.tx_empty)
                begin
                    if (st.is_write)
                    begin
                        if (!st.reg_sent)
                        begin
                            st_next.reg_sent = 1'b1;
                            st_next.pos      = '0;
                            res.data_kind    = i2cseq_pkg::KIND_REG;
                            res.out_byte     = st.reg_byte;
                        end
                        else if (st.pos < st.len)
                        begin
                            res.data_kind = i2cseq_pkg::KIND_DATA;
                            res.out_byte  = buf_byte;
                            res.out_index = st.pos;
                            st_next.pos   = st.pos + 8'd1;
                        end
                        if (st_next.pos >= st.len)
                        begin
                            st_next.mask[i2cseq_pkg::EN_TX] = 1'b0;
                        end
                    end
                    else if (!st.reg_sent)
                    begin
                        st_next.reg_sent = 1'b1;
                        res.data_kind    = i2cseq_pkg::KIND_REG;
                        res.out_byte     = st.reg_byte;
                        st_next.mask[i2cseq_pkg::EN_TX] = 1'b0;
                    end
                end
            end
            i2cseq_pkg::ACT_ERROR:
            begin
                if (item.error_flags != 5'd0)
                begin
                    st_next.err      = 1'b1;
                    res.stop_request = !item.error_flags[i2cseq_pkg::ERR_ARB_LOST];
                    st_next.mask     = '0;
                    st_next.phase    = i2cseq_pkg::PHASE_IDLE;
                    st_next.busy     = 1'b0;
                end
            end
            default:
            begin
                // loads touch only the buffer; unused codes do nothing
            end
        endcase
        res.busy_res = st_next.busy;
        res.error    = st_next.err;
    end

endmodule
`default_nettype wire

[rtl/core/i2c_master_transfer_sequencer.sv]
// Top level: I2C master register read/write transfer sequencer, streaming in and out.
// A result passes through the input register, then the result register; one item per cycle
//   sustained while m_tready does not stall the output, including loads and sends.
// The write buffer is a RAM read ahead of use, as the item is accepted, at the byte position
//   left by the item in front; a load to that same entry written as it is read is forwarded.
// Reset (rst_n low, async) clears both pipeline valids and all sequencer state; the
//   write buffer is not cleared and an entry reads as unknown until loaded.
`default_nettype none
module i2c_master_transfer_sequencer #(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // from bit 0: dev_addr[6:0], reg_addr[14:7], byte_count[22:15], data_byte[30:23],
    // buffer_index[38:31], stop_detected[39], nack_seen[40], transfer_complete[41],
    // rx_not_empty[42], tx_empty[43], error_flags[48:44], zero pad [55:49]
    input  wire logic [55:0] s_tdata,
    // from bit 0: action[2:0]
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // from bit 0: accepted[0], ctl_valid[1], ctl_slave_addr[9:2], ctl_byte_count[18:10],
    // ctl_receive[19], ctl_auto_end[20], out_byte[28:21], out_index[36:29],
    // stop_request[37], busy_res[38], error[39]
    output logic [39:0]      m_tdata,
    // from bit 0: data_kind[1:0]
    output logic [1:0]       m_tuser
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic                in_valid_reg;
    i2cseq_pkg::item_t   item_reg;
    logic                out_valid_reg;
    i2cseq_pkg::result_t res_reg;
    i2cseq_pkg::state_t  st_reg;
    i2cseq_pkg::state_t  st_next;
    i2cseq_pkg::result_t res_next;
    i2cseq_pkg::item_t   item_in;

    logic                advance;
    logic                s_accept;

    // write buffer access
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    rd_pos;
    logic [AW-1:0] rd_addr;
    logic          rd_in_range;
    logic [7:0]    ram_q;
    logic          fwd_reg;
    logic [7:0]    fwd_data_reg;
    logic          oob_reg;
    logic [7:0]    buf_byte;

    // the item in the input register moves on when the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign item_in.action            = i2cseq_pkg::action_t'(s_tuser);
    assign item_in.dev_addr          = s_tdata[6:0];
    assign item_in.reg_addr          = s_tdata[14:7];
    assign item_in.byte_count        = s_tdata[22:15];
    assign item_in.data_byte         = s_tdata[30:23];
    assign item_in.buffer_index      = s_tdata[38:31];
    assign item_in.stop_detected     = s_tdata[39];
    assign item_in.nack_seen         = s_tdata[40];
    assign item_in.transfer_complete = s_tdata[41];
    assign item_in.rx_not_empty      = s_tdata[42];
    assign item_in.tx_empty          = s_tdata[43];
    assign item_in.error_flags       = s_tdata[48:44];

    i2cseq_step u_step (
        .st       (st_reg),
        .item     (item_reg),
        .buf_byte (buf_byte),
        .st_next  (st_next),
        .res      (res_next)
    );

    // Loads write when they leave the input register; loads past the end are dropped.
    assign wr_en   = advance && item_reg.action == i2cseq_pkg::ACT_LOAD
                     && ({1'b0, item_reg.buffer_index} < 9'(BUFFER_DEPTH));
    assign wr_addr = item_reg.buffer_index[AW-1:0];

    // Prefetch for the incoming item: byte position as it stands after the item ahead.
    assign rd_pos      = advance ? st_next.pos : st_reg.pos;
    assign rd_addr     = rd_pos[AW-1:0];
    assign rd_in_range = {1'b0, rd_pos} < 9'(BUFFER_DEPTH);

    i2cseq_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item_reg.data_byte),
        .rd_en   (s_accept),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    assign buf_byte = oob_reg ? 8'd0 : (fwd_reg ? fwd_data_reg : ram_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            if (s_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            item_reg     <= item_in;
            fwd_reg      <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg <= item_reg.data_byte;
            oob_reg      <= !rd_in_range;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.data_kind;
    assign m_tdata  = {res_reg.error, res_reg.busy_res, res_reg.stop_request,
                       res_reg.out_index, res_reg.out_byte, res_reg.ctl_auto_end,
                       res_reg.ctl_receive, res_reg.ctl_byte_count, res_reg.ctl_slave_addr,
                       res_reg.ctl_valid, res_reg.accepted};

    // no event source stays enabled once the transfer is over
    a_idle_mask_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !st_reg.busy |-> st_reg.mask == 6'd0)
        else $error("enable mask set while not busy");

    // a held item leaves the sequencer state untouched
    a_stall_state: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> $stable(st_reg) && in_valid_reg)
        else $error("state moved while item stalled");

    // a received byte index always lies inside the programmed length
    a_rx_index: assert property (@(posedge clk) disable iff (!rst_n)
        $past(advance) && out_valid_reg && res_reg.data_kind == i2cseq_pkg::KIND_RX
        |-> res_reg.out_index < st_reg.len)
        else $error("receive index beyond length");

    // an accepted start always carries a control word that reports busy
    a_start_ctl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.accepted |-> res_reg.ctl_valid && res_reg.busy_res)
        else $error("accepted start without control word");

endmodule
`default_nettype wire
